// ----- rtl/adnp_pkg.sv -----
// ----------------------------------------------------------------------------
// adnp_pkg
// Shared types, constants and the place-weight table of the decimal parser.
// ----------------------------------------------------------------------------
package adnp_pkg;

    // fixed output field width
    localparam int OUT_BITS  = 48;

    // number format
    localparam int INT_BITS  = 31;
    localparam int FRAC_BITS = 16;

    // magnitude limit, never more than the output can carry
    localparam int SUM_BITS  = INT_BITS + FRAC_BITS;
    localparam int MAG_BITS  = (SUM_BITS >= OUT_BITS - 1) ? OUT_BITS - 1 : SUM_BITS;
    localparam int IACC_W    = MAG_BITS - FRAC_BITS;
    localparam int FACC_W    = 32;

    localparam logic [MAG_BITS-1:0] MAX_MAG   = '1;
    localparam logic [IACC_W-1:0]   INT_LIMIT = '1;

    // place-weight index, saturates on the first zero weight
    localparam int WT_IDX_W = 4;
    localparam logic [WT_IDX_W-1:0] WT_LAST = 4'd9;

    // ascii codes
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        PH_SKIP = 3'b001,
        PH_INT  = 3'b010,
        PH_FRAC = 3'b100
    } t_phase;

    typedef struct packed {
        t_phase                phase;
        logic                  negative;
        logic                  overflowed;
        logic [IACC_W-1:0]     iacc;
        logic [FACC_W-1:0]     facc;
        logic [WT_IDX_W-1:0]   wt_idx;
    } t_num_state;

    typedef struct packed {
        logic [OUT_BITS-1:0] value;
        logic                saturated;
    } t_result;

    localparam t_num_state NUM_CLEAR = '{
        phase:      PH_SKIP,
        negative:   1'b0,
        overflowed: 1'b0,
        iacc:       '0,
        facc:       '0,
        wt_idx:     '0
    };

    // 0.1 in Q0.32 divided by ten per step, truncated
    function automatic logic [FACC_W-1:0] place_weight(input logic [WT_IDX_W-1:0] idx);
        logic [FACC_W-1:0] w;
        case (idx)
            4'd0:    w = 32'h1999_999A;
            4'd1:    w = 32'h028F_5C29;
            4'd2:    w = 32'h0041_8937;
            4'd3:    w = 32'h0006_8DB8;
            4'd4:    w = 32'h0000_A7C5;
            4'd5:    w = 32'h0000_10C6;
            4'd6:    w = 32'h0000_01AD;
            4'd7:    w = 32'h0000_002A;
            4'd8:    w = 32'h0000_0004;
            default: w = 32'h0000_0000;
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/adnp_step.sv -----
// ----------------------------------------------------------------------------
// adnp_step
// Next parser state and finished result for one byte against current state.
// ----------------------------------------------------------------------------
module adnp_step (
    input  adnp_pkg::t_num_state i_state,
    input  logic [7:0]           i_byte,
    input  logic                 i_frac_mode,
    output adnp_pkg::t_num_state o_state,
    output logic                 o_emit,
    output adnp_pkg::t_result    o_result
);
    import adnp_pkg::*;

    logic                       is_digit;
    logic [7:0]                 diff;
    logic [3:0]                 digit;
    logic [IACC_W-1:0]          int_base;
    logic                       ov_base;
    logic [IACC_W+3:0]          int_x10;
    logic                       int_ov_nx;
    logic [IACC_W-1:0]          int_acc_nx;
    logic [FACC_W+3:0]          frac_prod;
    logic [FACC_W+4:0]          frac_sum;
    logic [FACC_W-1:0]          frac_nx;
    logic [IACC_W+FACC_W-1:0]   wide;
    logic [MAG_BITS-1:0]        mag;
    logic [OUT_BITS-1:0]        mag_ext;

    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign diff     = i_byte - CH_ZERO;
    assign digit    = diff[3:0];

    // integer digit: acc*10 + d, clamp at the limit
    assign int_base   = (i_state.phase == PH_INT) ? i_state.iacc : '0;
    assign ov_base    = (i_state.phase == PH_INT) ? i_state.overflowed : 1'b0;
    assign int_x10    = ({4'b0, int_base} << 3) + ({4'b0, int_base} << 1)
                      + {{IACC_W{1'b0}}, digit};
    assign int_ov_nx  = ov_base || (int_x10[IACC_W+3:IACC_W] != 4'd0);
    assign int_acc_nx = int_ov_nx ? INT_LIMIT : int_x10[IACC_W-1:0];

    // fraction digit: acc + weight*d, clamp at all ones
    assign frac_prod = {4'b0, place_weight(i_state.wt_idx)} * {{FACC_W{1'b0}}, digit};
    assign frac_sum  = {5'b0, i_state.facc} + {1'b0, frac_prod};
    assign frac_nx   = (frac_sum[FACC_W+4:FACC_W] != 5'd0) ? '1 : frac_sum[FACC_W-1:0];

    // result assembly from current state
    assign wide    = {i_state.iacc, i_state.facc} >> (FACC_W - FRAC_BITS);
    assign mag     = i_state.overflowed ? MAX_MAG : wide[MAG_BITS-1:0];
    assign mag_ext = {{(OUT_BITS-MAG_BITS){1'b0}}, mag};

    assign o_result.value     = i_state.negative ? (~mag_ext + 1'b1) : mag_ext;
    assign o_result.saturated = i_state.overflowed;

    always_comb begin
        o_state = i_state;
        o_emit  = 1'b0;
        case (i_state.phase)
            PH_INT: begin
                if (is_digit) begin
                    o_state.iacc       = int_acc_nx;
                    o_state.overflowed = int_ov_nx;
                end else if (i_byte == CH_DOT && i_frac_mode) begin
                    o_state.phase = PH_FRAC;
                end else begin
                    o_emit  = 1'b1;
                    o_state = NUM_CLEAR;
                end
            end
            PH_FRAC: begin
                if (is_digit) begin
                    o_state.facc = frac_nx;
                    if (i_state.wt_idx != WT_LAST) begin
                        o_state.wt_idx = i_state.wt_idx + 1'b1;
                    end
                end else begin
                    o_emit  = 1'b1;
                    o_state = NUM_CLEAR;
                end
            end
            default: begin
                o_state = NUM_CLEAR;
                if (i_byte == CH_MINUS) begin
                    o_state.negative = 1'b1;
                    o_state.phase    = PH_INT;
                end else if (is_digit) begin
                    o_state.iacc       = int_acc_nx;
                    o_state.overflowed = int_ov_nx;
                    o_state.phase      = PH_INT;
                end
            end
        endcase
    end

endmodule

// ----- rtl/ascii_decimal_number_parser.sv -----
// ----------------------------------------------------------------------------
// ascii_decimal_number_parser
// Parses a stream of ascii bytes into signed Q31.16 numbers, with saturation.
// ----------------------------------------------------------------------------
//
//  channel   direction  signals                          meaning
//  -------   ---------  -------------------------------  ----------------------
//  in        sink       i_in_valid / o_in_ready          one ascii byte
//                       i_byte_req
//  out       source     o_out_valid / i_out_ready        one parsed number
//                       o_value, o_saturated
//  cfg       sink       i_cfg_wr_en, i_cfg_wr_data       fraction mode, no wait
//
//  one byte a cycle sustained while no result stalls; a byte waits in the
//  input register and reaches the parser state when it moves on, and the
//  result of a byte that ends a number is loaded at that same edge
//  the per-byte work is a x10 shift-add or a 32x4 weight multiply-add
//  between the input register and the state/result registers
//  reset clears the state, fraction mode and both valid flags, no sweep
//  a stalled result only holds off a byte that would end another number
// ----------------------------------------------------------------------------
module ascii_decimal_number_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_byte_req,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [adnp_pkg::OUT_BITS-1:0] o_value,
    output logic                            o_saturated,
    input  logic                            i_cfg_wr_en,
    input  logic                            i_cfg_wr_data
);
    import adnp_pkg::*;

    // input register
    logic               r_in_vld;
    logic [7:0]         r_byte;
    // parser state and configuration
    t_num_state         r_state;
    t_num_state         n_state;
    logic               r_frac_mode;
    // result register
    logic               r_out_vld;
    t_result            r_result;
    t_result            n_result;

    logic               step_emit;
    logic               advance;
    logic               in_xfer;
    logic               out_xfer;

    adnp_step u_step (
        .i_state     (r_state),
        .i_byte      (r_byte),
        .i_frac_mode (r_frac_mode),
        .o_state     (n_state),
        .o_emit      (step_emit),
        .o_result    (n_result)
    );

    // the held byte moves on unless it ends a number while a result is stuck
    assign advance    = r_in_vld && (!step_emit || !r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_xfer   = r_out_vld && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_byte <= i_byte_req;
        end
    end

    // number state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= NUM_CLEAR;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_frac_mode <= i_cfg_wr_data;
        end
    end

    // result register, loaded by the terminating byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance && step_emit) begin
            r_out_vld <= 1'b1;
        end else if (out_xfer) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_emit) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_value     = r_result.value;
    assign o_saturated = r_result.saturated;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // a clamped result carries the full magnitude
    a_sat_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_result.saturated) |->
            (r_result.value == {{(OUT_BITS-MAG_BITS){1'b0}}, MAX_MAG}) ||
            (r_result.value == ~{{(OUT_BITS-MAG_BITS){1'b0}}, MAX_MAG} + 1'b1))
        else $error("saturated result without full magnitude");

    // overflow is only held while a number is being collected
    a_ovf_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.overflowed |-> (r_state.phase == PH_INT || r_state.phase == PH_FRAC))
        else $error("overflow flag outside a number");

    // skipping means a cleared number
    a_skip_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_SKIP) |->
            (r_state.iacc == '0 && r_state.facc == '0 && !r_state.negative))
        else $error("stale number state while skipping");

    // a terminating byte behind a stuck result must not be replaced
    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && step_emit && r_out_vld && !i_out_ready) |=>
            (r_in_vld && $stable(r_byte) && $stable(r_state)))
        else $error("terminating byte lost under output stall");

endmodule
